/* hdl/upbt_pkg.sv */
`default_nettype none
package upbt_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 64;
  localparam int unsigned PORT_COUNT_DEF   = 65536;
  localparam int unsigned MAX_OUT          = 64;

  typedef enum logic [1:0] {
    OP_BIND   = 2'd0,
    OP_UNBIND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_HEAD = 3'd1,
    CUR_NEXT = 3'd2,
    CUR_ZERO = 3'd3,
    CUR_INC  = 3'd4
  } cur_sel_t;

  typedef struct packed {
    logic     latch;
    cur_sel_t cur_sel;
    logic     prev_ld;
    logic     empty_ld;
    logic     cnt_inc;
    logic     wr_new;
    logic     link_prev;
    logic     unlink;
    logic     cand_inc;
    logic     clear;
    logic     emit;
    status_t  emit_status;
    logic     emit_port;
    logic     emit_rec;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic hit_empty;
    logic pass;
    logic sock_match;
    logic nx_nil;
    logic cur_valid;
    logic cur_last;
    logic cand_match;
    logic cand_last;
    logic cnt_last;
    logic head_ins;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/upbt_datapath.sv */
`default_nettype none
module upbt_datapath #(
  parameter int unsigned POOL_ENTRIES = 64,
  parameter int unsigned PORT_COUNT   = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  upbt_pkg::cmd_t   cmd,
  output upbt_pkg::sts_t   sts,
  input  logic [1:0]       operation,
  input  logic [9:0]       socket_id,
  input  logic [31:0]      ip_addr,
  input  logic [15:0]      port,
  input  logic             share_addr,
  input  logic             share_port,
  output logic             valid,
  output logic [2:0]       status,
  output logic [15:0]      port_out,
  output logic [9:0]       socket_out,
  output logic [31:0]      ip_out,
  output logic             share_addr_out,
  output logic             share_port_out,
  output logic             last
);
  import upbt_pkg::*;

  localparam int AW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int IW   = $clog2(POOL_ENTRIES + 1);
  localparam int PW   = $clog2(PORT_COUNT);
  localparam int RW   = 44 + PW;
  localparam int MAXC = (MAX_OUT < POOL_ENTRIES) ? MAX_OUT : POOL_ENTRIES;
  localparam int CW   = (MAXC > 1) ? $clog2(MAXC) : 1;
  localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

  op_t           op_l;
  logic [9:0]    sock_l;
  logic [31:0]   ip_l;
  logic [15:0]   port_l;
  logic          ra_l;
  logic          rp_l;
  logic [IW-1:0] cur;
  logic [IW-1:0] prev;
  logic [IW-1:0] hd;
  logic          empty_q;
  logic [CW-1:0] cnt;
  logic [PW-1:0] cand;
  logic [POOL_ENTRIES-1:0] valid_bits;

  logic [RW-1:0] rec_mem  [0:POOL_ENTRIES-1];
  logic [IW-1:0] next_mem [0:POOL_ENTRIES-1];
  logic [IW-1:0] head_mem [0:PORT_COUNT-1];
  logic [RW-1:0] rec_q;
  logic [IW-1:0] next_q;
  logic [IW-1:0] head_q;

  logic [AW-1:0] ca;
  logic [AW-1:0] pa;
  logic [PW-1:0] pp;
  logic [IW-1:0] nx;
  logic          cur_nil;
  logic          cur_vb;
  logic [31:0]   ipo;
  logic          orp;
  logic [PW-1:0] rec_port;

  assign ca       = cur[AW-1:0];
  assign pa       = prev[AW-1:0];
  assign pp       = port_l[PW-1:0];
  assign nx       = (next_q >= NIL) ? NIL : next_q;
  assign cur_nil  = (cur >= NIL);
  assign cur_vb   = valid_bits[ca];
  assign ipo      = rec_q[41:10];
  assign orp      = rec_q[43];
  assign rec_port = rec_q[RW-1:44];

  always_comb begin
    sts            = '0;
    sts.op         = op_l;
    sts.in_range   = ({1'b0, port_l} < 17'(PORT_COUNT));
    sts.hit_empty  = cur_nil || !cur_vb || (rec_port != pp);
    sts.pass       = ((ipo != ip_l) && (ipo != '0) && (ip_l != '0))
                  || ((ipo != ip_l) && ((ipo == '0) || (ip_l != '0)) && (ra_l || rp_l))
                  || ((ipo == ip_l) && (ip_l != '0) && rp_l && orp);
    sts.sock_match = (rec_q[9:0] == sock_l);
    sts.nx_nil     = (nx == NIL);
    sts.cur_valid  = !cur_nil && cur_vb;
    sts.cur_last   = (cur == IW'(POOL_ENTRIES - 1));
    sts.cand_match = (rec_port == cand);
    sts.cand_last  = (cand == PW'(PORT_COUNT - 1));
    sts.cnt_last   = (cnt == CW'(MAXC - 1));
    sts.head_ins   = (ip_l == '0) || empty_q;
  end

  // memory reads, registered
  always_ff @(posedge clk) begin
    rec_q  <= rec_mem[ca];
    next_q <= next_mem[ca];
    head_q <= head_mem[pp];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      rec_mem[ca] <= {pp, rp_l, ra_l, ip_l, sock_l};
    end
    if (cmd.wr_new) begin
      next_mem[ca] <= (sts.head_ins && !empty_q) ? hd : NIL;
    end else if (cmd.link_prev) begin
      next_mem[pa] <= cur;
    end else if (cmd.unlink && (prev != NIL)) begin
      next_mem[pa] <= nx;
    end
    if (cmd.clear) begin
      head_mem[cand] <= NIL;
    end else if (cmd.wr_new && sts.head_ins) begin
      head_mem[pp] <= cur;
    end else if (cmd.unlink && (prev == NIL)) begin
      head_mem[pp] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.wr_new) begin
      valid_bits[ca] <= 1'b1;
    end else if (cmd.unlink) begin
      valid_bits[ca] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
    end else if (cmd.latch) begin
      op_l    <= op_t'(operation);
      sock_l  <= socket_id;
      ip_l    <= ip_addr;
      port_l  <= port;
      ra_l    <= share_addr;
      rp_l    <= share_port;
      prev    <= NIL;
      cnt     <= '0;
      cand    <= '0;
      empty_q <= 1'b0;
    end else begin
      if (cmd.prev_ld)  prev    <= cur;
      if (cmd.empty_ld) empty_q <= sts.hit_empty;
      if (cmd.cnt_inc)  cnt     <= cnt + CW'(1);
      if (cmd.cand_inc) cand    <= cand + PW'(1);
    end
    case (cmd.cur_sel)
      CUR_HEAD: begin
        cur <= head_q;
        hd  <= head_q;
      end
      CUR_NEXT: cur <= nx;
      CUR_ZERO: cur <= '0;
      CUR_INC:  cur <= cur + IW'(1);
      default:  cur <= cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
    if (cmd.emit) begin
      status         <= cmd.emit_status;
      port_out       <= cmd.emit_port ? 16'(cand) : 16'd0;
      socket_out     <= cmd.emit_rec ? rec_q[9:0] : 10'd0;
      ip_out         <= cmd.emit_rec ? ipo : 32'd0;
      share_addr_out <= cmd.emit_rec ? rec_q[42] : 1'b0;
      share_port_out <= cmd.emit_rec ? orp : 1'b0;
      last           <= cmd.emit_last;
    end
  end

endmodule
`default_nettype wire

/* hdl/upbt_ctrl.sv */
`default_nettype none
module upbt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  upbt_pkg::sts_t sts,
  output upbt_pkg::cmd_t cmd
);
  import upbt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_HEAD_LD, S_ENTRY_RD, S_ENTRY, S_SLOT, S_LINK,
    S_FREE_RD, S_FREE_CHK, S_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   first;
  logic   first_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    first_next = first;
    case (state)
      S_CLEAR: begin
        // null one port head per cycle
        cmd.clear    = 1'b1;
        cmd.cand_inc = 1'b1;
        if (sts.cand_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          cmd.cur_sel = CUR_ZERO;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == OP_FREE) begin
          state_next = S_FREE_RD;
        end else if (!sts.in_range) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = (sts.op == OP_BIND) ? ST_CONFLICT : ST_EMPTY;
          state_next      = S_IDLE;
        end else begin
          state_next = S_HEAD_LD;
        end
      end
      S_HEAD_LD: begin
        cmd.cur_sel = CUR_HEAD;
        first_next  = 1'b1;
        state_next  = S_ENTRY_RD;
      end
      S_ENTRY_RD: state_next = S_ENTRY;
      S_ENTRY: begin
        first_next = 1'b0;
        case (sts.op)
          OP_BIND: begin
            if (first && sts.hit_empty) begin
              cmd.empty_ld = 1'b1;
              cmd.cur_sel  = CUR_ZERO;
              state_next   = S_SLOT;
            end else if (!sts.pass) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_CONFLICT;
              state_next      = S_IDLE;
            end else begin
              cmd.prev_ld = 1'b1;
              if (sts.nx_nil) begin
                cmd.cur_sel = CUR_ZERO;
                state_next  = S_SLOT;
              end else begin
                cmd.cur_sel = CUR_NEXT;
                state_next  = S_ENTRY_RD;
              end
            end
          end
          OP_UNBIND: begin
            if (first && sts.hit_empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_next      = S_IDLE;
            end else if (sts.sock_match || sts.nx_nil) begin
              cmd.unlink    = sts.sock_match;
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              state_next    = S_IDLE;
            end else begin
              cmd.prev_ld = 1'b1;
              cmd.cur_sel = CUR_NEXT;
              state_next  = S_ENTRY_RD;
            end
          end
          default: begin
            if (first && sts.hit_empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_next      = S_IDLE;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_rec  = 1'b1;
              cmd.cnt_inc   = 1'b1;
              cmd.emit_last = sts.nx_nil || sts.cnt_last;
              if (sts.nx_nil || sts.cnt_last) begin
                state_next = S_IDLE;
              end else begin
                cmd.cur_sel = CUR_NEXT;
                state_next  = S_ENTRY_RD;
              end
            end
          end
        endcase
      end
      S_SLOT: begin
        if (!sts.cur_valid) begin
          cmd.wr_new = 1'b1;
          if (sts.head_ins) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_LINK;
          end
        end else if (sts.cur_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_POOL_FULL;
          state_next      = S_IDLE;
        end else begin
          cmd.cur_sel = CUR_INC;
        end
      end
      S_LINK: begin
        cmd.link_prev = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      S_FREE_RD: state_next = S_FREE_CHK;
      S_FREE_CHK: begin
        if (sts.cur_valid && sts.cand_match) begin
          if (sts.cand_last) begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = ST_NO_FREE;
            state_next      = S_IDLE;
          end else begin
            cmd.cand_inc = 1'b1;
            cmd.cur_sel  = CUR_ZERO;
            state_next   = S_FREE_RD;
          end
        end else if (sts.cur_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_port = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.cur_sel = CUR_INC;
          state_next  = S_FREE_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/udp_port_bind_table.sv */
// Bind, unbind and lookup load the port head, then read and check one chain entry at a time;
//   lookup strobes one result per entry visited, up to MAX_OUT (or POOL_ENTRIES if smaller).
//   Bind then scans the pool for a free slot and links it at the head or at the chain tail.
// Free-port checks candidate ports from 0 up, scanning the pool entries for each candidate.
// One transfer in flight; busy drops as the final result strobes; no receiver stall.
// Reset clears the entry valid flops, then a pass over all PORT_COUNT ports (busy high) nulls heads.
`default_nettype none
module udp_port_bind_table #(
  parameter int unsigned POOL_ENTRIES = upbt_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned PORT_COUNT   = upbt_pkg::PORT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [9:0]  socket_id,
  input  logic [31:0] ip_addr,
  input  logic [15:0] port,
  input  logic        share_addr,
  input  logic        share_port,
  output logic        valid,
  output logic [2:0]  status,
  output logic [15:0] port_out,
  output logic [9:0]  socket_out,
  output logic [31:0] ip_out,
  output logic        share_addr_out,
  output logic        share_port_out,
  output logic        last
);
  import upbt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the walk over the port chain, the free-port scan and the head clear
  upbt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // hold entry pool, chain links, port heads and result registers
  upbt_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .PORT_COUNT   (PORT_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .socket_id      (socket_id),
    .ip_addr        (ip_addr),
    .port           (port),
    .share_addr     (share_addr),
    .share_port     (share_port),
    .valid          (valid),
    .status         (status),
    .port_out       (port_out),
    .socket_out     (socket_out),
    .ip_out         (ip_out),
    .share_addr_out (share_addr_out),
    .share_port_out (share_port_out),
    .last           (last)
  );

endmodule
`default_nettype wire

/* hdl/upbt_checker.sv */
`default_nettype none
module upbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        valid,
  input logic [2:0]  status,
  input logic        last
);
  import upbt_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("result strobe after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

  a_more_results: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> busy)
    else $error("non-final result while idle");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (valid && (status != ST_OK)) |-> last)
    else $error("error status not final");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (status <= ST_EMPTY))
    else $error("status code out of range");

endmodule

bind udp_port_bind_table upbt_checker u_upbt_checker (.*);
`default_nettype wire
